[rtl/tfn_pkg.sv]
// Shared constants for the triangle face normal block.
package tfn_pkg;
  localparam int unsigned CoordWidth     = 16;
  localparam int unsigned NormalFracBits = 14;
  localparam int unsigned OutBits        = 16;
  localparam int unsigned NormTopBit     = 29;
  localparam int unsigned MagWidth       = 30;
  localparam int unsigned SqWidth        = 62;
  localparam int unsigned LenWidth       = 31;
  localparam int unsigned ShiftWidth     = 6;
endpackage

[rtl/tfn_sqrt.sv]
// Pipelined integer square root, two result bits per stage.
module tfn_sqrt #(
  parameter int unsigned InWidth   = 62,
  parameter int unsigned TagWidth  = 1,
  parameter int unsigned BitsPerSt = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic [InWidth-1:0]     rad_i,
  input  logic [TagWidth-1:0]    tag_i,
  output logic                   valid_o,
  output logic [InWidth/2-1:0]   root_o,
  output logic [TagWidth-1:0]    tag_o
);
  localparam int unsigned RW     = InWidth / 2;
  localparam int unsigned NStage = (RW + BitsPerSt - 1) / BitsPerSt;

  logic [NStage:0]               vld_q;
  logic [InWidth-1:0]            rem_q  [NStage+1];
  logic [RW-1:0]                 root_q [NStage+1];
  logic [TagWidth-1:0]           tag_q  [NStage+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rem_q[0]  = rad_i;
    root_q[0] = '0;
    tag_q[0]  = tag_i;
  end

  for (genvar s = 0; s < NStage; s++) begin : g_st
    logic [InWidth-1:0] rem_d;
    logic [RW-1:0]      root_d;
    always_comb begin
      logic [InWidth+1:0] trial;
      rem_d  = rem_q[s];
      root_d = root_q[s];
      trial  = '0;
      for (int k = 0; k < BitsPerSt; k++) begin
        if (s * BitsPerSt + k < RW) begin
          trial = ({2'b00, root_d} << (RW - (s * BitsPerSt + k)))
                  | ({{(InWidth+1){1'b0}}, 1'b1} << (2 * (RW - 1 - (s * BitsPerSt + k))));
          if ({2'b00, rem_d} >= trial) begin
            rem_d  = rem_d - trial[InWidth-1:0];
            root_d = root_d | (RW'(1) << (RW - 1 - (s * BitsPerSt + k)));
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1]  <= rem_d;
        root_q[s+1] <= root_d;
        tag_q[s+1]  <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[NStage];
  assign root_o  = root_q[NStage];
  assign tag_o   = tag_q[NStage];
endmodule

[rtl/tfn_div.sv]
// Pipelined restoring divider for one normal component, one quotient bit per stage.
module tfn_div #(
  parameter int unsigned NumWidth = 45,
  parameter int unsigned DenWidth = 31,
  parameter int unsigned QWidth   = 16
) (
  input  logic                  clk_i,
  input  logic                  adv_i,
  input  logic [NumWidth-1:0]   num_i,
  input  logic [DenWidth-1:0]   den_i,
  output logic [QWidth-1:0]     quo_o
);
  // Quotient is below 2^QWidth, so only the low QWidth quotient bits are formed.
  localparam int unsigned RemW = DenWidth + 1;

  logic [RemW-1:0]     rem_q [QWidth+1];
  logic [NumWidth-1:0] num_q [QWidth+1];
  logic [DenWidth-1:0] den_q [QWidth+1];
  logic [QWidth-1:0]   quo_q [QWidth+1];

  always_comb begin
    rem_q[0] = RemW'(num_i >> QWidth);
    num_q[0] = num_i;
    den_q[0] = den_i;
    quo_q[0] = '0;
  end

  for (genvar s = 0; s < QWidth; s++) begin : g_st
    logic [RemW:0]     sh;
    logic [RemW-1:0]   rem_d;
    logic [QWidth-1:0] quo_d;
    always_comb begin
      sh    = {rem_q[s], num_q[s][QWidth-1-s]};
      quo_d = quo_q[s];
      if (sh >= {2'b00, den_q[s]}) begin
        rem_d = RemW'(sh - {2'b00, den_q[s]});
        quo_d[QWidth-1-s] = 1'b1;
      end else begin
        rem_d = RemW'(sh);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1] <= rem_d;
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        quo_q[s+1] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QWidth];
endmodule

[rtl/triangle_face_normal.sv]
// Top level: pipelined triangle face normal, cross product then normalisation.
//
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, ax_i .. cz_i         | request in
//  out     | out_valid, out_stall, normal_*_o, degen  | request out
//
//  One triangle accepted per clock while the output is not stalled. The pipeline
//  has seven front stages, sixteen square root stages for the 62-bit sum of
//  squares, NORMAL_FRAC_BITS + 1 divider stages and the output register.
//  Reset clears valid bits only.
//  A stall on the output holds the whole pipeline; in_stall follows out_stall
//  while the last stage is full, so no request is lost or repeated.
module triangle_face_normal #(
  parameter int unsigned COORD_WIDTH      = tfn_pkg::CoordWidth,
  parameter int unsigned NORMAL_FRAC_BITS = tfn_pkg::NormalFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] az_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] bz_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] cz_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z_o,
  output logic                          degenerate_o
);
  localparam int unsigned EW   = COORD_WIDTH + 1;
  localparam int unsigned PW   = 2 * EW;
  localparam int unsigned CW   = PW + 1;
  localparam int unsigned MW   = tfn_pkg::MagWidth;
  localparam int unsigned TOP  = tfn_pkg::NormTopBit;
  localparam int unsigned SW   = tfn_pkg::SqWidth;
  localparam int unsigned LW   = tfn_pkg::LenWidth;
  localparam int unsigned OB   = NORMAL_FRAC_BITS + 2;
  localparam int unsigned NW   = MW + NORMAL_FRAC_BITS + 1;
  localparam int unsigned QW   = NORMAL_FRAC_BITS + 1;
  localparam int unsigned PBW  = $clog2(CW + 1);
  localparam int unsigned TAGW = 3 * MW + 4;

  logic adv;
  assign adv      = !out_stall || !out_valid;
  assign in_stall = !adv;

  // Stage 1: edges.
  logic              v1_q;
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q[0] <= EW'(bx_i) - EW'(ax_i);
      e1_q[1] <= EW'(by_i) - EW'(ay_i);
      e1_q[2] <= EW'(bz_i) - EW'(az_i);
      e2_q[0] <= EW'(cx_i) - EW'(ax_i);
      e2_q[1] <= EW'(cy_i) - EW'(ay_i);
      e2_q[2] <= EW'(cz_i) - EW'(az_i);
    end
  end

  // Stage 2: six products.
  logic v2_q;
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q[0] <= e1_q[1] * e2_q[2];
      pb_q[0] <= e1_q[2] * e2_q[1];
      pa_q[1] <= e1_q[2] * e2_q[0];
      pb_q[1] <= e1_q[0] * e2_q[2];
      pa_q[2] <= e1_q[0] * e2_q[1];
      pb_q[2] <= e1_q[1] * e2_q[0];
    end
  end

  // Stage 3: cross components as sign and magnitude.
  logic v3_q;
  logic [CW-1:0] mg3_q [3];
  logic [2:0]    neg3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  for (genvar i = 0; i < 3; i++) begin : g_cr
    logic signed [CW-1:0] cr;
    assign cr = CW'(pa_q[i]) - CW'(pb_q[i]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg3_q[i] <= cr[CW-1];
        mg3_q[i]  <= cr[CW-1] ? CW'(-cr) : CW'(cr);
      end
    end
  end

  // Stage 4: leading one of the largest magnitude.
  logic v4_q;
  logic [CW-1:0]  mg4_q [3];
  logic [2:0]     neg4_q;
  logic [PBW-1:0] p4_q;
  logic           zero4_q;
  logic [CW-1:0]  orv;
  logic [PBW-1:0] p_d;
  assign orv = mg3_q[0] | mg3_q[1] | mg3_q[2];
  always_comb begin
    p_d = '0;
    for (int k = 0; k < CW; k++) begin
      if (orv[k]) p_d = PBW'(k);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mg4_q   <= mg3_q;
      neg4_q  <= neg3_q;
      p4_q    <= p_d;
      zero4_q <= (orv == '0);
    end
  end

  // Stage 5: scale so the largest magnitude has its top one at TOP.
  logic v5_q;
  logic [MW-1:0] m5_q [3];
  logic [2:0]    neg5_q;
  logic          zero5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end
  for (genvar i = 0; i < 3; i++) begin : g_sc
    logic [CW+MW-1:0] wide;
    always_comb begin
      if (p4_q > PBW'(TOP)) wide = (CW+MW)'(mg4_q[i]) >> (p4_q - PBW'(TOP));
      else                  wide = (CW+MW)'(mg4_q[i]) << (PBW'(TOP) - p4_q);
    end
    always_ff @(posedge clk_i) begin
      if (adv) m5_q[i] <= wide[MW-1:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
    end
  end

  // Stage 6: squares.
  logic v6_q;
  logic [2*MW-1:0] sq6_q [3];
  logic [MW-1:0]   m6_q [3];
  logic [2:0]      neg6_q;
  logic            zero6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (adv) v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sq6_q[i] <= m5_q[i] * m5_q[i];
      m6_q    <= m5_q;
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  // Stage 7: sum of squares.
  logic v7_q;
  logic [SW-1:0] s7_q;
  logic [TAGW-1:0] tag7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (adv) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_q   <= SW'(sq6_q[0]) + SW'(sq6_q[1]) + SW'(sq6_q[2]);
      tag7_q <= {zero6_q, neg6_q, m6_q[2], m6_q[1], m6_q[0]};
    end
  end

  logic            vs;
  logic [LW-1:0]   len;
  logic [TAGW-1:0] tags;
  tfn_sqrt #(.InWidth(SW), .TagWidth(TAGW), .BitsPerSt(2)) u_sqrt (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v7_q), .rad_i(s7_q), .tag_i(tag7_q),
    .valid_o(vs), .root_o(len), .tag_o(tags)
  );

  // Divider entry: numerator m * 2^F + len/2, divisor len (forced to 1 when len is zero).
  logic [LW-1:0] lenx;
  assign lenx = (len == '0) ? LW'(1) : len;

  logic [QW-1:0] quo [3];
  for (genvar i = 0; i < 3; i++) begin : g_dv
    logic [NW-1:0] num;
    assign num = (NW'(tags[i*MW +: MW]) << NORMAL_FRAC_BITS) + NW'(lenx >> 1);
    tfn_div #(.NumWidth(NW), .DenWidth(LW), .QWidth(QW)) u_div (
      .clk_i, .adv_i(adv), .num_i(num), .den_i(lenx), .quo_o(quo[i])
    );
  end

  logic [QW:0] vd_q;
  logic [3:0]  sd_q [QW+1];
  always_comb begin
    vd_q[0] = vs;
    sd_q[0] = tags[TAGW-1 -: 4];
  end
  for (genvar s = 0; s < QW; s++) begin : g_dl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd_q[s+1] <= 1'b0;
      else if (adv) vd_q[s+1] <= vd_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (adv) sd_q[s+1] <= sd_q[s];
    end
  end

  // Output register: clamp, apply sign, flag degenerate.
  logic out_valid_q;
  logic [OB-1:0] nrm_q [3];
  logic degen_q;
  logic [3:0] sgn;
  assign sgn = sd_q[QW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= vd_q[QW];
  end
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [OB-1:0] q;
    assign q = (quo[i] > QW'(1 << NORMAL_FRAC_BITS)) ? OB'(1 << NORMAL_FRAC_BITS)
                                                      : OB'(quo[i]);
    always_ff @(posedge clk_i) begin
      if (adv) nrm_q[i] <= sgn[3] ? '0 : (sgn[i] ? OB'(-q) : q);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) degen_q <= sgn[3];
  end

  assign out_valid    = out_valid_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = degen_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(normal_x_o) && $stable(degenerate_o))
    else $error("output changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result not zero");
endmodule
